// File: rtl/core/are_pkg.sv
`timescale 1ns / 1ps
package are_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned LANE_N = 4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  localparam logic [1:0] REG_INIT_RELAX = 2'd0;
  localparam logic [1:0] REG_TOLERANCE  = 2'd1;
  localparam logic [1:0] REG_MAX_ITER   = 2'd2;

  localparam logic [7:0] MAX_ITER_RST = 8'd50;

  // request to the shared multiply/divide unit
  typedef struct packed {
    logic start;
    logic div;
  } are_md_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/are_vec_mem.sv
`timescale 1ns / 1ps
module are_vec_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                                              clk_i,
  input  logic [are_pkg::LANE_N-1:0]                        we_i,
  input  logic [AW-1:0]                                     waddr_i,
  input  logic [are_pkg::LANE_N*are_pkg::DATA_W-1:0]        wdata_i,
  input  logic                                              re_i,
  input  logic [AW-1:0]                                     raddr_i,
  output logic [are_pkg::LANE_N*are_pkg::DATA_W-1:0]        rdata_o
);
  import are_pkg::*;

  logic [LANE_N*DATA_W-1:0] mem [DEPTH];

  // write enabled lanes
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANE_N; l++) begin
      if (we_i[l]) begin
        mem[waddr_i][l*DATA_W +: DATA_W] <= wdata_i[l*DATA_W +: DATA_W];
      end
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/core/are_muldiv.sv
`timescale 1ns / 1ps
module are_muldiv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  are_pkg::are_md_req_t req_i,
  input  logic [63:0]          opa_i,
  input  logic [63:0]          opb_i,
  output logic                 done_o,
  output logic [63:0]          hi_o,
  output logic [33:0]          quot_o
);
  import are_pkg::*;

  logic         busy_q;
  logic         div_q;
  logic [6:0]   cnt_q;
  logic         done_q;
  logic [127:0] prod_q;
  logic [63:0]  a_q;
  logic [63:0]  rem_q;
  logic [34:0]  q_q;
  logic         sat_q;

  logic [64:0]  acc;
  logic         carry;
  logic [63:0]  rem_sh;
  logic         qb;
  logic [34:0]  q_nx;
  logic         last;

  always_comb begin
    acc    = {1'b0, prod_q[127:64]} + (prod_q[0] ? {1'b0, a_q} : 65'd0);
    carry  = rem_q[63];
    rem_sh = {rem_q[62:0], prod_q[127]};
    qb     = carry || (rem_sh >= a_q);
    q_nx   = {q_q[33:0], qb};
    last   = div_q ? (cnt_q == 7'd127) : (cnt_q == 7'd63);
  end

  // control: one product bit or one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        div_q  <= req_i.div;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath: shift-add multiply, restoring divide of the held product
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      if (req_i.div) begin
        a_q   <= opb_i;
        rem_q <= '0;
        q_q   <= '0;
        sat_q <= 1'b0;
      end else begin
        a_q    <= opa_i;
        prod_q <= {64'd0, opb_i};
      end
    end else if (busy_q) begin
      if (div_q) begin
        prod_q <= {prod_q[126:0], 1'b0};
        rem_q  <= qb ? rem_sh - a_q : rem_sh;
        if (!sat_q) begin
          q_q <= q_nx;
          if (q_nx > 35'h200000000) begin
            sat_q <= 1'b1;
          end
        end
      end else begin
        prod_q <= {acc, prod_q[63:1]};
      end
    end
  end

  assign done_o = done_q;
  assign hi_o   = prod_q[127:64];
  assign quot_o = sat_q ? 34'h200000000 : q_q[33:0];

endmodule

// File: rtl/core/aitken_relaxation_engine.sv
`timescale 1ns / 1ps
// Aitken under-relaxation engine. Load requests (operation 0) fill the guess
// vector at one per cycle while the engine is idle. Each solver request
// (operation 1) passes through the vector memory read, residual and product
// stages before the next request is taken. The request marked last starts
// the end-of-vector pass: the convergence test on the bit-serial multiplier,
// then the Aitken omega update (a multiply and a divide on the same unit)
// when the vector has not converged after its first iteration, then a read,
// relax and write back of each element, held while the output is stalled.
// No request is taken during that pass. One result is emitted per element.
module aitken_relaxation_engine #(
  parameter int unsigned VECTOR_LEN = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic signed [31:0] sample_value_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] relaxed_value_o,
  output logic               converged_o,
  output logic [7:0]         iteration_o,
  output logic               last_result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import are_pkg::*;

  localparam int unsigned AW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam logic [CNT_W-1:0] VLEN = CNT_W'(VECTOR_LEN);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_ELEM_RD   = 4'd1;
  localparam logic [3:0] ST_ELEM_MUL  = 4'd2;
  localparam logic [3:0] ST_ELEM_ACC  = 4'd3;
  localparam logic [3:0] ST_TOL       = 4'd4;
  localparam logic [3:0] ST_CMUL      = 4'd5;
  localparam logic [3:0] ST_CMUL_WAIT = 4'd6;
  localparam logic [3:0] ST_OMUL_WAIT = 4'd7;
  localparam logic [3:0] ST_ODIV_WAIT = 4'd8;
  localparam logic [3:0] ST_PASS_RD   = 4'd9;
  localparam logic [3:0] ST_PASS_MUL  = 4'd10;
  localparam logic [3:0] ST_PASS_WR   = 4'd11;

  logic [3:0]         state_q, state_d;
  logic [29:0]        init_q;
  logic [31:0]        tol_q;
  logic [7:0]         maxit_q;
  logic signed [31:0] omega_q;
  logic [7:0]         iter_q;
  logic [CNT_W-1:0]   elem_cnt_q;
  logic [CNT_W-1:0]   load_cnt_q;
  logic [CNT_W-1:0]   idx_q;
  logic signed [63:0] num_q;
  logic [63:0]        den_q;
  logic [63:0]        nsq_q;
  logic [63:0]        dsq_q;
  logic [63:0]        tol2_q;
  logic               conv_q;
  logic               neg_q;
  logic [7:0]         iter_out_q;

  logic signed [31:0] v_q;
  logic               last_q;
  logic signed [31:0] r_q;
  logic signed [32:0] d_q;
  logic signed [31:0] p_q;
  logic [63:0]        pd_q, dd_q, vv_q, rr_q;
  logic signed [31:0] g_q;
  logic signed [31:0] res_q;
  logic signed [31:0] nw_q;
  logic signed [63:0] om_prod_q;

  logic               out_valid_q;
  logic signed [31:0] out_val_q;
  logic               out_conv_q;
  logic [7:0]         out_iter_q;
  logic               out_last_q;

  logic               in_acc;
  logic [LANE_N-1:0]  mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [LANE_N*DATA_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [LANE_N*DATA_W-1:0] mem_rdata;

  are_md_req_t        md_req;
  logic [63:0]        md_opa, md_opb;
  logic               md_done;
  logic [63:0]        md_hi;
  logic [33:0]        md_quot;

  logic signed [32:0] diff_rd;
  logic signed [31:0] r_rd;
  logic signed [32:0] d_rd;
  logic signed [65:0] pd_full, dd_full, vv_full, rr_full;
  logic signed [32:0] v_ext, r_ext, p_ext;
  logic               conv_now;
  logic [31:0]        om_mag;
  logic [31:0]        om_lim;
  logic [63:0]        num_mag;
  logic signed [63:0] relax_sum;
  logic signed [31:0] pass_val;
  logic               out_free;
  logic               pass_last;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign pass_last   = (idx_q + CNT_W'(1)) == elem_cnt_q;

  // residual and difference from read data
  always_comb begin
    diff_rd = {v_q[31], v_q} - {mem_rdata[31], mem_rdata[31:0]};
    r_rd    = sat32(64'(diff_rd));
    d_rd    = {r_rd[31], r_rd} - {mem_rdata[95], mem_rdata[95:64]};
    v_ext   = {v_q[31], v_q};
    r_ext   = {r_q[31], r_q};
    p_ext   = {p_q[31], p_q};
    pd_full = d_q * p_ext;
    dd_full = d_q * d_q;
    vv_full = v_ext * v_ext;
    rr_full = r_ext * r_ext;
  end

  // omega helpers
  always_comb begin
    conv_now  = (dsq_q <= md_hi) || (iter_q >= maxit_q);
    om_mag    = omega_q[31] ? 32'(-omega_q) : 32'(omega_q);
    om_lim    = (om_mag > {2'b00, init_q}) ? {2'b00, init_q} : om_mag;
    num_mag   = num_q[63] ? 64'(-num_q) : 64'(num_q);
    relax_sum = 64'(g_q) + (om_prod_q >>> 28);
    pass_val  = conv_q ? nw_q : sat32(relax_sum);
  end

  // memory ports
  always_comb begin
    mem_we    = '0;
    mem_waddr = elem_cnt_q[AW-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = elem_cnt_q[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_acc && operation_i == OP_LOAD && load_cnt_q < VLEN) begin
          mem_we    = 4'b0001;
          mem_waddr = load_cnt_q[AW-1:0];
          mem_wdata = {96'd0, sample_value_i};
        end
        mem_re = in_acc && operation_i == OP_SOLVE;
      end
      ST_ELEM_MUL: begin
        mem_we    = 4'b1010;
        mem_wdata = {v_q, 32'd0, r_q, 32'd0};
      end
      ST_PASS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q[AW-1:0];
      end
      ST_PASS_WR: begin
        if (out_free) begin
          mem_we    = conv_q ? 4'b0001 : 4'b0101;
          mem_waddr = idx_q[AW-1:0];
          mem_wdata = {32'd0, res_q, 32'd0, pass_val};
        end
      end
      default: begin
      end
    endcase
  end

  // shared unit requests
  always_comb begin
    md_req = '0;
    md_opa = {32'd0, om_mag};
    md_opb = num_mag;
    case (state_q)
      ST_CMUL: begin
        md_req.start = 1'b1;
        md_opa       = nsq_q;
        md_opb       = tol2_q;
      end
      ST_CMUL_WAIT: begin
        md_req.start = md_done && !conv_now && iter_q != 8'd0 && den_q != 64'd0;
      end
      ST_OMUL_WAIT: begin
        md_req.start = md_done;
        md_req.div   = 1'b1;
        md_opb       = den_q;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && operation_i == OP_SOLVE) begin
          if (elem_cnt_q < VLEN) begin
            state_d = ST_ELEM_RD;
          end else if (last_element_i) begin
            state_d = ST_TOL;
          end
        end
      end
      ST_ELEM_RD:  state_d = ST_ELEM_MUL;
      ST_ELEM_MUL: state_d = ST_ELEM_ACC;
      ST_ELEM_ACC: state_d = last_q ? ST_TOL : ST_IDLE;
      ST_TOL:      state_d = ST_CMUL;
      ST_CMUL:     state_d = ST_CMUL_WAIT;
      ST_CMUL_WAIT: begin
        if (md_done) begin
          state_d = md_req.start ? ST_OMUL_WAIT : ST_PASS_RD;
        end
      end
      ST_OMUL_WAIT: begin
        if (md_done) begin
          state_d = ST_ODIV_WAIT;
        end
      end
      ST_ODIV_WAIT: begin
        if (md_done) begin
          state_d = ST_PASS_RD;
        end
      end
      ST_PASS_RD:  state_d = ST_PASS_MUL;
      ST_PASS_MUL: state_d = ST_PASS_WR;
      ST_PASS_WR: begin
        if (out_free) begin
          state_d = pass_last ? ST_IDLE : ST_PASS_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      init_q      <= '0;
      tol_q       <= '0;
      maxit_q     <= MAX_ITER_RST;
      omega_q     <= '0;
      iter_q      <= '0;
      elem_cnt_q  <= '0;
      load_cnt_q  <= '0;
      idx_q       <= '0;
      num_q       <= '0;
      den_q       <= '0;
      nsq_q       <= '0;
      dsq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // configuration writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_INIT_RELAX: init_q  <= cfg_data_i[29:0];
          REG_TOLERANCE:  tol_q   <= cfg_data_i;
          REG_MAX_ITER:   maxit_q <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end

      // advance load index
      if (in_acc && operation_i == OP_LOAD) begin
        if (last_element_i) begin
          load_cnt_q <= '0;
        end else if (load_cnt_q < VLEN) begin
          load_cnt_q <= load_cnt_q + CNT_W'(1);
        end
      end

      // accumulate sums
      if (state_q == ST_ELEM_ACC) begin
        num_q      <= num_q + ($signed(pd_q) >>> 7);
        den_q      <= den_q + (dd_q >> 7);
        nsq_q      <= nsq_q + (vv_q >> 7);
        dsq_q      <= dsq_q + (rr_q >> 7);
        elem_cnt_q <= elem_cnt_q + CNT_W'(1);
      end

      // omega update on a vector that has not converged
      if (state_q == ST_CMUL_WAIT && md_done && !conv_now && iter_q == 8'd0) begin
        if (omega_q == 32'sd0) begin
          omega_q <= $signed({2'b00, init_q});
        end else begin
          omega_q <= omega_q[31] ? $signed(-om_lim) : $signed(om_lim);
        end
      end
      if (state_q == ST_ODIV_WAIT && md_done) begin
        if (md_quot == 34'd0) begin
          omega_q <= '0;
        end else if (neg_q) begin
          omega_q <= (md_quot > 34'h080000000) ? 32'sh80000000 : $signed(-md_quot[31:0]);
        end else begin
          omega_q <= (md_quot > 34'h07fffffff) ? 32'sh7fffffff : $signed(md_quot[31:0]);
        end
      end

      if (state_q == ST_CMUL_WAIT) begin
        idx_q <= '0;
      end

      // emit results and close the vector
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_PASS_WR && out_free) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_q + CNT_W'(1);
        if (pass_last) begin
          iter_q     <= conv_q ? 8'd0 : iter_q + 8'd1;
          elem_cnt_q <= '0;
          num_q      <= '0;
          den_q      <= '0;
          nsq_q      <= '0;
          dsq_q      <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q    <= sample_value_i;
      last_q <= last_element_i;
    end
    if (state_q == ST_ELEM_RD) begin
      r_q <= r_rd;
      d_q <= d_rd;
      p_q <= mem_rdata[95:64];
    end
    if (state_q == ST_ELEM_MUL) begin
      pd_q <= pd_full[63:0];
      dd_q <= dd_full[63:0];
      vv_q <= vv_full[63:0];
      rr_q <= rr_full[63:0];
    end
    if (state_q == ST_TOL) begin
      tol2_q <= 64'(tol_q) * 64'(tol_q);
    end
    if (state_q == ST_CMUL_WAIT && md_done) begin
      conv_q     <= conv_now;
      iter_out_q <= iter_q;
      neg_q      <= (omega_q[31] == num_q[63]);
    end
    if (state_q == ST_PASS_MUL) begin
      g_q       <= mem_rdata[31:0];
      res_q     <= mem_rdata[63:32];
      nw_q      <= mem_rdata[127:96];
      om_prod_q <= 64'(omega_q) * 64'($signed(mem_rdata[63:32]));
    end
    if (state_q == ST_PASS_WR && out_free) begin
      out_val_q  <= pass_val;
      out_conv_q <= conv_q;
      out_iter_q <= iter_out_q;
      out_last_q <= pass_last;
    end
  end

  are_vec_mem #(
    .DEPTH (VECTOR_LEN),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  are_muldiv u_md (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .opa_i  (md_opa),
    .opb_i  (md_opb),
    .done_o (md_done),
    .hi_o   (md_hi),
    .quot_o (md_quot)
  );

  assign out_valid_o     = out_valid_q;
  assign relaxed_value_o = out_val_q;
  assign converged_o     = out_conv_q;
  assign iteration_o     = out_iter_q;
  assign last_result_o   = out_last_q;

endmodule
